FILE: rtl/msb_first_bit_packer_defines.svh
// assertion macros for the msb-first bit packer checker
// no dependencies; included by the checker file only
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// implication checked on every rising clock edge, off while in reset
`define MFBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same, with the consequent checked in the cycle after the antecedent
`define MFBP_ASSERT_NEXT(label, ante, cons, msg) \
  `MFBP_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/mfbp_pkg.sv
// shared types and constants of the msb-first bit packer
// no dependencies
package mfbp_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 6;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned FillW   = 3;
  localparam int unsigned NbytesW = 3;
  localparam int unsigned AccW    = ValueW + ByteW;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  // one classified item waiting for the byte stage
  typedef struct packed {
    logic [ValueW-1:0]  word;      // completed bytes, first byte in the top bits
    logic [NbytesW-1:0] nbytes;    // 0..4 bytes
    logic               rejected;
  } entry_t;

endpackage

FILE: rtl/mfbp_front.sv
// front stage: accepts items, checks widths, packs bits into the accumulator
// depends on mfbp_pkg
module mfbp_front #(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  mfbp_pkg::action_e             action_i,
  input  logic [mfbp_pkg::ValueW-1:0]   value_i,
  input  logic [mfbp_pkg::CountW-1:0]   bit_count_i,
  input  logic                          push_ready_i,
  output logic                          in_ready_o,
  output logic                          push_o,
  output mfbp_pkg::entry_t              entry_o
);

  logic [mfbp_pkg::ByteW-1:0]   pending_q, pending_d;
  logic [mfbp_pkg::FillW-1:0]   filled_q, filled_d;
  logic                         accept;
  logic                         reject;
  logic [mfbp_pkg::AccW-1:0]    acc;
  logic [mfbp_pkg::CountW-1:0]  shamt;
  logic [mfbp_pkg::CountW-1:0]  total;
  logic [mfbp_pkg::ByteW-1:0]   rest;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;

  assign reject = (bit_count_i > mfbp_pkg::CountW'(mfbp_pkg::ValueW))
               || (32'(bit_count_i) > MAX_CODE_BITS)
               || ((value_i >> bit_count_i) != '0);

  // place the code right after the pending bits, msb first
  assign shamt = mfbp_pkg::CountW'(mfbp_pkg::AccW) - mfbp_pkg::CountW'(filled_q) - bit_count_i;
  assign acc   = {pending_q, {mfbp_pkg::ValueW{1'b0}}}
               | ({{mfbp_pkg::ByteW{1'b0}}, value_i} << shamt);
  assign total = mfbp_pkg::CountW'(filled_q) + bit_count_i;

  always_comb begin
    case (total[5:3])
      3'd0:    rest = acc[39:32];
      3'd1:    rest = acc[31:24];
      3'd2:    rest = acc[23:16];
      3'd3:    rest = acc[15:8];
      default: rest = acc[7:0];
    endcase
  end

  always_comb begin
    pending_d = pending_q;
    filled_d  = filled_q;
    entry_o   = '0;
    if (action_i == mfbp_pkg::ACT_FLUSH) begin
      entry_o.word   = {pending_q, {(mfbp_pkg::ValueW - mfbp_pkg::ByteW){1'b0}}};
      entry_o.nbytes = (filled_q != '0) ? mfbp_pkg::NbytesW'(1) : '0;
      if (accept) begin
        pending_d = '0;
        filled_d  = '0;
      end
    end else if (reject) begin
      entry_o.rejected = 1'b1;
    end else begin
      entry_o.word   = acc[mfbp_pkg::AccW-1 -: mfbp_pkg::ValueW];
      entry_o.nbytes = total[5:3];
      if (accept) begin
        pending_d = rest;
        filled_d  = total[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      filled_q  <= '0;
    end else begin
      pending_q <= pending_d;
      filled_q  <= filled_d;
    end
  end

endmodule

FILE: rtl/mfbp_fifo.sv
// two-entry queue between the front and the byte stage
// depends on mfbp_pkg
module mfbp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mfbp_pkg::entry_t  entry_i,
  output logic              push_ready_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output mfbp_pkg::entry_t  head_o
);

  mfbp_pkg::entry_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/mfbp_back.sv
// byte stage: emits each head entry's bytes, or one status result, one per cycle
// while the output is ready; depends on mfbp_pkg
module mfbp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  mfbp_pkg::entry_t            head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mfbp_pkg::ByteW-1:0]  out_byte_o,
  output logic                        byte_valid_o,
  output logic                        rejected_o,
  output logic                        last_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;
  logic       has_bytes;

  assign has_bytes    = (head_i.nbytes != '0);
  assign out_valid_o  = head_valid_i;
  assign fire         = head_valid_i && out_ready_i;
  assign byte_valid_o = has_bytes;
  assign rejected_o   = head_i.rejected;
  assign last_o       = !has_bytes
                     || (mfbp_pkg::NbytesW'(idx_q) == head_i.nbytes - mfbp_pkg::NbytesW'(1));
  assign pop_o        = fire && last_o;

  always_comb begin
    if (!has_bytes) begin
      out_byte_o = '0;
    end else begin
      case (idx_q)
        2'd0:    out_byte_o = head_i.word[31:24];
        2'd1:    out_byte_o = head_i.word[23:16];
        2'd2:    out_byte_o = head_i.word[15:8];
        default: out_byte_o = head_i.word[7:0];
      endcase
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

FILE: rtl/msb_first_bit_packer.sv
// msb-first bit packer: packs variable-length codes (0..32 bits) into bytes,
// first bit in bit 7. each input item yields one result per completed byte,
// or a single status result when no byte completes or the write is refused;
// the final result of an item carries tlast. a write whose value does not fit
// its bit count (or whose count exceeds 32 or MAX_CODE_BITS) is refused and
// leaves the accumulator untouched. a flush emits a partly filled byte padded
// with zeros and clears the accumulator. the front classifies an item and
// updates the accumulator in its accept cycle, so a new item can enter every
// cycle while the queue has room; a two-entry queue hands the work to the byte
// stage, which sends one result per cycle while the output is ready. an item
// yields max(1, bytes) results, up to 4; the byte output port sets the sustained
// rate. depends on mfbp_pkg, mfbp_front, mfbp_fifo and mfbp_back.
module msb_first_bit_packer #(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value, [37:32] bit_count, rest zero
  input  logic        s_axis_tuser,   // [0] action: 0 write, 1 flush
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] rejected
  output logic        m_axis_tlast    // last result of the item
);

  // front to queue
  logic             push;
  logic             push_ready;
  mfbp_pkg::entry_t push_entry;
  // queue to byte stage
  logic             head_valid;
  logic             pop;
  mfbp_pkg::entry_t head;
  mfbp_pkg::action_e action;

  assign action = mfbp_pkg::action_e'(s_axis_tuser);

  mfbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .action_i     (action),
    .value_i      (s_axis_tdata[31:0]),
    .bit_count_i  (s_axis_tdata[37:32]),
    .push_ready_i (push_ready),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // queue lets the front keep accepting while bytes drain
  mfbp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  mfbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .byte_valid_o (m_axis_tuser[0]),
    .rejected_o   (m_axis_tuser[1]),
    .last_o       (m_axis_tlast)
  );

endmodule

FILE: rtl/mfbp_checker.sv
// port-level checks for the msb-first bit packer, bound to the top level
// depends on msb_first_bit_packer_defines.svh
`include "msb_first_bit_packer_defines.svh"

module mfbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result holds still
  `MFBP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  // a status result carries a zero byte and closes its item
  `MFBP_ASSERT(a_status_last, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0), "status result not last or byte nonzero")

  // a refused write never carries a byte
  `MFBP_ASSERT(a_reject_nobyte, m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0], "refused write carries a byte")

  // the queue never stays full once the last result of an item is taken
  `MFBP_ASSERT_NEXT(a_ready_back, !s_axis_tready && m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "input not released after an item finished")

endmodule

bind msb_first_bit_packer mfbp_checker u_mfbp_checker (.*);

FILE: sim/tb.sv
// testbench for the msb-first bit packer: directed codes, a stall-free random
// burst, then random code streams with random stalls on both, checked against a local model
// depends on mfbp_pkg and msb_first_bit_packer
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CodeBits = 32;
  localparam int unsigned IdlePct  = 33;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       rejected;
    logic       last;
  } packer_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [31:0] value, [37:32] bit_count, rest zero
  logic        s_axis_tuser;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic [1:0]  m_axis_tuser;   // [0] byte_valid, [1] rejected
  logic        m_axis_tlast;

  // model of the bit accumulator
  logic [7:0]     acc_byte;
  int unsigned    acc_fill;
  packer_result_t packed_results_q[$];

  int mismatch_count;
  bit no_idle;

  msb_first_bit_packer #(
    .MAX_CODE_BITS(CodeBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // appends the expected results of one item, updating the accumulator
  function automatic void pack_code(input mfbp_pkg::action_e act, input logic [31:0] val,
                                    input logic [5:0] cnt);
    packer_result_t res[4];
    int n;
    int i;
    n = 0;
    if (act == mfbp_pkg::ACT_FLUSH) begin
      if (acc_fill != 0) begin
        res[n] = '{out_byte: acc_byte, byte_valid: 1'b1, rejected: 1'b0, last: 1'b0};
        n++;
      end
      acc_byte = '0;
      acc_fill = 0;
    end else if (cnt > 32 || cnt > CodeBits || (cnt < 32 && (val >> cnt) != 0)) begin
      // refused: accumulator left alone
      res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, rejected: 1'b1, last: 1'b0};
      n = 1;
    end else begin
      for (i = int'(cnt) - 1; i >= 0; i--) begin
        acc_byte[7 - acc_fill] = val[i];
        acc_fill++;
        if (acc_fill == 8) begin
          res[n] = '{out_byte: acc_byte, byte_valid: 1'b1, rejected: 1'b0, last: 1'b0};
          n++;
          acc_byte = '0;
          acc_fill = 0;
        end
      end
    end
    // no completed byte: one status result
    if (n == 0) begin
      res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, rejected: 1'b0, last: 1'b0};
      n = 1;
    end
    res[n-1].last = 1'b1;
    for (i = 0; i < n; i++) packed_results_q = {packed_results_q, res[i]};
  endfunction

  // called and returns at a falling edge; tvalid stays high for a back-to-back item
  task automatic send_item(input mfbp_pkg::action_e act, input logic [31:0] val,
                           input logic [5:0] cnt);
    while (!no_idle && $urandom_range(99, 0) < IdlePct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    pack_code(act, val, cnt);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, cnt, val};
    s_axis_tuser  = act;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (packed_results_q.size() != 0) @(negedge clk_i);
  endtask

  // mostly well-formed codes and flushes, some noise with any count
  task automatic send_random_item();
    logic [31:0] val;
    logic [5:0]  cnt;
    logic [63:0] mask;
    int pick;
    pick = $urandom_range(99, 0);
    val  = $urandom();
    cnt  = 6'($urandom_range(32, 0));
    mask = (64'd1 << cnt) - 64'd1;
    if (pick < 15) begin
      send_item(mfbp_pkg::ACT_FLUSH, val, 6'($urandom_range(63, 0)));
    end else if (pick < 82) begin
      send_item(mfbp_pkg::ACT_WRITE, val & mask[31:0], cnt);
    end else if (pick < 90) begin
      // short codes keep the accumulator at odd fill levels
      cnt  = 6'($urandom_range(7, 0));
      mask = (64'd1 << cnt) - 64'd1;
      send_item(mfbp_pkg::ACT_WRITE, val & mask[31:0], cnt);
    end else begin
      send_item(mfbp_pkg::ACT_WRITE, val, 6'($urandom_range(63, 0)));
    end
  endtask

  task automatic test_directed();
    send_item(mfbp_pkg::ACT_FLUSH, 32'h0000_0000, 6'd0);    // flush with nothing pending
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_0000, 6'd0);    // zero bits
    send_item(mfbp_pkg::ACT_WRITE, 32'hFFFF_FFFF, 6'd32);   // widest code, all ones
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_0001, 6'd1);
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_0001, 6'd0);    // nonzero value in zero bits
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_0002, 6'd1);    // value too wide
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_0000, 6'd33);   // count beyond 32
    send_item(mfbp_pkg::ACT_WRITE, 32'hFFFF_FFFF, 6'd63);
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_002A, 6'd6);    // seven bits pending
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_0000, 6'd32);   // four bytes from a partial byte
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_0000, 6'd0);    // zero bits with bits pending
    send_item(mfbp_pkg::ACT_FLUSH, 32'hDEAD_BEEF, 6'd40);   // flush ignores its fields
    send_item(mfbp_pkg::ACT_FLUSH, 32'h0000_0000, 6'd0);
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_00A5, 6'd8);
    send_item(mfbp_pkg::ACT_WRITE, 32'h7FFF_FFFF, 6'd31);
    send_item(mfbp_pkg::ACT_WRITE, 32'h8000_0000, 6'd31);
    send_item(mfbp_pkg::ACT_WRITE, 32'h8000_0001, 6'd32);
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_0000, 6'd1);    // completes the pending byte
    send_item(mfbp_pkg::ACT_WRITE, 32'h0000_1234, 6'd16);
    send_item(mfbp_pkg::ACT_FLUSH, 32'hFFFF_FFFF, 6'd63);
    wait_drained();
  endtask

  task automatic test_random_burst();
    no_idle = 1'b1;
    repeat (60) send_random_item();
    no_idle = 1'b0;
  endtask

  task automatic test_random_stalls();
    repeat (90) send_random_item();
    // hold the sender until the byte side has caught up
    wait_drained();
    repeat (100) send_random_item();
    wait_drained();
  endtask

  // result side: random back-pressure and checking
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = no_idle || ($urandom_range(99, 0) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    packer_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (packed_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %h user %b last %b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = packed_results_q.pop_front();
        if (m_axis_tdata !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", m_axis_tdata, want.out_byte));
        if (m_axis_tuser[0] !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, want %b", m_axis_tuser[0],
                                    want.byte_valid));
        if (m_axis_tuser[1] !== want.rejected)
          report_mismatch($sformatf("rejected %b, want %b", m_axis_tuser[1], want.rejected));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    acc_byte       = '0;
    acc_fill       = 0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_burst();
    test_random_stalls();

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && packed_results_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: msb_first_bit_packer.f
+incdir+rtl
rtl/mfbp_pkg.sv
rtl/mfbp_front.sv
rtl/mfbp_fifo.sv
rtl/mfbp_back.sv
rtl/msb_first_bit_packer.sv
rtl/mfbp_checker.sv
sim/tb.sv
